[design/sbm_pkg.sv]
// sbm_pkg: shared types, codes and constants of the serial bank mapper
// no dependencies; imported by every module of the mapper
`default_nettype none

package sbm_pkg;

  // access space codes carried in the input tuser
  typedef enum logic [1:0] {
    SPACE_CHR = 2'd0,
    SPACE_PRG_ROM = 2'd1,
    SPACE_PRG_RAM = 2'd2,
    SPACE_NONE = 2'd3
  } space_e;

  // target memory codes carried in the output tuser
  typedef enum logic [1:0] {
    TGT_CHR_ROM = 2'd0,
    TGT_CHR_RAM = 2'd1,
    TGT_PRG_ROM = 2'd2,
    TGT_PRG_RAM = 2'd3
  } target_e;

  // serial load destination, chosen by bus address bits 14:13
  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_CHR_LOW = 2'd1,
    SEL_CHR_HIGH = 2'd2,
    SEL_PRG_BANK = 2'd3
  } reg_sel_e;

  // program banking modes held in control bits 3:2
  typedef enum logic [1:0] {
    PRG_SWITCH_32K = 2'd0,
    PRG_SWITCH_32K_ALT = 2'd1,
    PRG_FIX_FIRST = 2'd2,
    PRG_FIX_LAST = 2'd3
  } prg_mode_e;

  // configuration register indexes (byte address 4*i)
  localparam logic CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic CFG_PRG_RAM_BASE = 1'b1;

  localparam int unsigned AddrW = 16;
  localparam int unsigned DataW = 8;
  localparam int unsigned OffsetW = 18;
  localparam int unsigned BankW = 5;
  localparam int unsigned RamBaseW = 15;
  localparam int unsigned PaddrW = 3;

  localparam logic [BankW-1:0] ControlReset = 5'h0C;
  localparam logic [BankW-1:0] BankCountReset = 5'd8;
  localparam logic [2:0] ShiftLast = 3'd4;

  // bank and control registers loaded through the serial port
  typedef struct packed {
    logic [BankW-1:0] control;
    logic [BankW-1:0] chr_low;
    logic [BankW-1:0] chr_high;
    logic [BankW-1:0] prg_bank;
  } bank_regs_t;

  // one decoded bus access
  typedef struct packed {
    logic [1:0] mode;
    logic is_write;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } access_t;

endpackage

`default_nettype wire

[design/serial_bank_mapper.sv]
// serial_bank_mapper: bank-switching cartridge mapper with a serial register port
// pipeline: an input transfer passes through the input register, then the result register
// throughput: one access per cycle; the result register holds while the master side stalls
// reset: rst_ni clears valids and shifter, control to 0x0C, banks to 0, bank count to 8
// depends on sbm_pkg, sbm_serial_port, sbm_translate
`default_nettype none

module serial_bank_mapper (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // input access stream
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // bus_address[15:0], write_data[23:16]
  input  wire logic [2:0] s_axis_tuser,   // mode[1:0], is_write[2]
  // result stream
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [23:0] m_axis_tdata,       // phys_offset[17:0], mirror_mode[19:18], zero[23:20]
  output logic [3:0] m_axis_tuser,        // access_ok[0], target_memory[2:1], register_loaded[3]
  // configuration port
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [sbm_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import sbm_pkg::*;

  logic in_valid_q;
  access_t in_q;
  logic advance;
  logic cfg_write;
  logic [BankW-1:0] bank_count_q;
  logic [RamBaseW-1:0] ram_base_q;
  bank_regs_t regs;
  logic [1:0] mirror_next;
  logic loaded;
  logic ok;
  logic [1:0] target;
  logic [OffsetW-1:0] offset;
  logic out_valid_q;
  logic out_ok_q;
  logic [1:0] out_target_q;
  logic [OffsetW-1:0] out_offset_q;
  logic [1:0] out_mirror_q;
  logic out_loaded_q;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_count_q <= BankCountReset;
      ram_base_q <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == CFG_PRG_BANK_COUNT) begin
        bank_count_q <= pwdata[BankW-1:0];
      end else begin
        ram_base_q <= pwdata[RamBaseW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == CFG_PRG_BANK_COUNT) begin
      prdata = {{(32-BankW){1'b0}}, bank_count_q};
    end else begin
      prdata = {{(32-RamBaseW){1'b0}}, ram_base_q};
    end
  end

  // handshake: the input stage moves on when the result register is free or drains
  assign advance = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.mode <= s_axis_tuser[1:0];
      in_q.is_write <= s_axis_tuser[2];
      in_q.addr <= s_axis_tdata[15:0];
      in_q.data <= s_axis_tdata[23:16];
    end
  end

  sbm_serial_port u_serial_port (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .fire_i(advance),
    .acc_i(in_q),
    .regs_o(regs),
    .mirror_next_o(mirror_next),
    .loaded_o(loaded)
  );

  sbm_translate u_translate (
    .acc_i(in_q),
    .regs_i(regs),
    .prg_bank_count_i(bank_count_q),
    .prg_ram_base_i(ram_base_q),
    .ok_o(ok),
    .target_o(target),
    .offset_o(offset)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_ok_q <= ok;
      out_target_q <= target;
      out_offset_q <= offset;
      out_mirror_q <= mirror_next;
      out_loaded_q <= loaded;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {4'b0000, out_mirror_q, out_offset_q};
  assign m_axis_tuser = {out_loaded_q, out_target_q, out_ok_q};

endmodule

`default_nettype wire

[design/sbm_serial_port.sv]
// sbm_serial_port: five-bit serial shift register and the four bank registers
// depends on sbm_pkg
`default_nettype none

module sbm_serial_port (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fire_i,
  input  wire sbm_pkg::access_t acc_i,
  output sbm_pkg::bank_regs_t regs_o,
  output logic [1:0] mirror_next_o,
  output logic loaded_o
);
  import sbm_pkg::*;

  logic [BankW-1:0] shift_q, shift_d;
  logic [2:0] count_q, count_d;
  bank_regs_t regs_q, regs_d;
  logic port_write;
  logic [BankW-1:0] shifted;

  // serial writes are program rom writes at 0x8000 and above
  assign port_write = (acc_i.mode == SPACE_PRG_ROM) && acc_i.is_write && acc_i.addr[15];
  assign shifted = {acc_i.data[0], shift_q[BankW-1:1]};

  // next state of the shifter and the bank registers
  always_comb begin
    shift_d = shift_q;
    count_d = count_q;
    regs_d = regs_q;
    loaded_o = 1'b0;
    if (port_write) begin
      if (acc_i.data[7]) begin
        shift_d = '0;
        count_d = '0;
      end else if (count_q == ShiftLast) begin
        shift_d = '0;
        count_d = '0;
        loaded_o = 1'b1;
        unique case (reg_sel_e'(acc_i.addr[14:13]))
          SEL_CONTROL: regs_d.control = shifted;
          SEL_CHR_LOW: regs_d.chr_low = shifted;
          SEL_CHR_HIGH: regs_d.chr_high = shifted;
          SEL_PRG_BANK: regs_d.prg_bank = shifted;
          default: regs_d.prg_bank = shifted;
        endcase
      end else begin
        shift_d = shifted;
        count_d = count_q + 3'd1;
      end
    end
  end

  // state registers, updated once per transfer taken into the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      count_q <= '0;
      regs_q.control <= ControlReset;
      regs_q.chr_low <= '0;
      regs_q.chr_high <= '0;
      regs_q.prg_bank <= '0;
    end else if (fire_i) begin
      shift_q <= shift_d;
      count_q <= count_d;
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;
  assign mirror_next_o = regs_d.control[1:0];

endmodule

`default_nettype wire

[design/sbm_translate.sv]
// sbm_translate: address translation of one access to target memory and offset
// depends on sbm_pkg
`default_nettype none

module sbm_translate (
  input  wire sbm_pkg::access_t acc_i,
  input  wire sbm_pkg::bank_regs_t regs_i,
  input  wire logic [sbm_pkg::BankW-1:0] prg_bank_count_i,
  input  wire logic [sbm_pkg::RamBaseW-1:0] prg_ram_base_i,
  output logic ok_o,
  output logic [1:0] target_o,
  output logic [sbm_pkg::OffsetW-1:0] offset_o
);
  import sbm_pkg::*;

  logic [OffsetW-1:0] chr_off;
  logic [OffsetW-1:0] prg_off;
  logic [OffsetW-1:0] ram_off;
  logic [3:0] bank;
  logic [3:0] last_bank;
  logic [3:0] window;
  logic [RamBaseW:0] ram_sum;

  // character offset, one 8K bank or two 4K banks
  always_comb begin
    if (!regs_i.control[4]) begin
      chr_off = {1'b0, regs_i.chr_low[4:1], acc_i.addr[12:0]};
    end else if (!acc_i.addr[12]) begin
      chr_off = {1'b0, regs_i.chr_low, acc_i.addr[11:0]};
    end else begin
      chr_off = {1'b0, regs_i.chr_high, acc_i.addr[11:0]};
    end
  end

  // program rom offset, 32K or one of the fixed 16K modes
  assign bank = regs_i.prg_bank[3:0];
  assign last_bank = prg_bank_count_i[3:0] - 4'd1;

  always_comb begin
    window = bank;
    unique case (prg_mode_e'(regs_i.control[3:2]))
      PRG_FIX_FIRST: window = acc_i.addr[14] ? bank : 4'd0;
      PRG_FIX_LAST: window = acc_i.addr[14] ? last_bank : bank;
      default: window = bank;
    endcase
    if (!regs_i.control[3]) begin
      prg_off = {bank[3:1], acc_i.addr[14:0]};
    end else begin
      prg_off = {window, acc_i.addr[13:0]};
    end
  end

  // program ram offset from the window base
  assign ram_sum = {1'b0, prg_ram_base_i} + {{(RamBaseW-12){1'b0}}, acc_i.addr[12:0]};
  assign ram_off = {{(OffsetW-RamBaseW-1){1'b0}}, ram_sum};

  // select by space; no access gives a zero offset
  always_comb begin
    ok_o = 1'b0;
    offset_o = '0;
    unique case (space_e'(acc_i.mode))
      SPACE_CHR: begin
        target_o = acc_i.is_write ? TGT_CHR_RAM : TGT_CHR_ROM;
        if (acc_i.addr[15:13] == 3'b000) begin
          ok_o = 1'b1;
          offset_o = chr_off;
        end
      end
      SPACE_PRG_ROM: begin
        target_o = TGT_PRG_ROM;
        if (acc_i.addr[15] && !acc_i.is_write) begin
          ok_o = 1'b1;
          offset_o = prg_off;
        end
      end
      SPACE_PRG_RAM: begin
        target_o = TGT_PRG_RAM;
        if (acc_i.addr[15:13] == 3'b011 && !regs_i.prg_bank[4]) begin
          ok_o = 1'b1;
          offset_o = ram_off;
        end
      end
      default: target_o = TGT_CHR_ROM;
    endcase
  end

endmodule

`default_nettype wire

[sim/serial_bank_mapper_checker.sv]
// serial_bank_mapper_checker: watches the access, result and register channels of the mapper
// keeps its own copy of the bank state and compares every result with the translation it predicts
// depends on sbm_pkg
`timescale 1ns / 1ps

module serial_bank_mapper_checker
  import sbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // access stream, as seen at the block
  input  logic                acc_tvalid_i,
  input  logic                acc_tready_i,
  input  logic [23:0]         acc_tdata_i,   // bus_address[15:0], write_data[23:16]
  input  logic [2:0]          acc_tuser_i,   // mode[1:0], is_write[2]
  // result stream, as seen at the block
  input  logic                res_tvalid_i,
  input  logic                res_tready_i,
  input  logic [23:0]         res_tdata_i,   // phys_offset[17:0], mirror_mode[19:18], zero[23:20]
  input  logic [3:0]          res_tuser_i,   // access_ok[0], target_memory[2:1], loaded[3]
  // register port
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [PaddrW-1:0]   paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic                pready_i,
  // totals for the testbench top
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  loads_o
);

  localparam int MaxReports = 10;
  localparam logic [2:0] SerialBits = 3'd5;
  localparam int ChrModeBit = 4;
  localparam int RamDisableBit = 4;

  typedef struct packed {
    logic               access_ok;
    logic [1:0]         target;
    logic [OffsetW-1:0] offset;
    logic [1:0]         mirror;
    logic               loaded;
  } translation_t;

  // mapper state as predicted here
  logic [4:0]          shift_word;
  logic [2:0]          shift_cnt;
  logic [BankW-1:0]    control;
  logic [BankW-1:0]    chr_low;
  logic [BankW-1:0]    chr_high;
  logic [BankW-1:0]    prg_bank;
  logic [BankW-1:0]    bank_count;
  logic [RamBaseW-1:0] ram_base;

  translation_t translations_q[$];

  // one bit of the serial register port; returns 1 when a register got loaded
  function automatic logic shift_in(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    if (data[7]) begin
      shift_word = '0;
      shift_cnt = '0;
      return 1'b0;
    end
    shift_word = {data[0], shift_word[4:1]};
    shift_cnt = shift_cnt + 3'd1;
    if (shift_cnt != SerialBits) return 1'b0;
    case (reg_sel_e'(addr[14:13]))
      SEL_CONTROL:  control = shift_word;
      SEL_CHR_LOW:  chr_low = shift_word;
      SEL_CHR_HIGH: chr_high = shift_word;
      default:      prg_bank = shift_word;
    endcase
    shift_word = '0;
    shift_cnt = '0;
    return 1'b1;
  endfunction

  // translate one access and apply its side effects on the bank state
  function automatic translation_t translate_access(input access_t acc);
    translation_t r;
    int unsigned  off;
    logic [3:0]   bank;
    logic [3:0]   window;
    r = '0;
    off = 0;
    bank = prg_bank[3:0];
    case (space_e'(acc.mode))
      SPACE_CHR: begin
        r.target = acc.is_write ? TGT_CHR_RAM : TGT_CHR_ROM;
        if (acc.addr < 16'h2000) begin
          r.access_ok = 1'b1;
          if (!control[ChrModeBit]) begin
            off = chr_low[4:1] * 32'h2000 + acc.addr[12:0];
          end else if (!acc.addr[12]) begin
            off = chr_low * 32'h1000 + acc.addr[11:0];
          end else begin
            off = chr_high * 32'h1000 + acc.addr[11:0];
          end
        end
      end
      SPACE_PRG_ROM: begin
        r.target = TGT_PRG_ROM;
        if (acc.addr[15]) begin
          if (acc.is_write) begin
            r.loaded = shift_in(acc.addr, acc.data);
          end else begin
            r.access_ok = 1'b1;
            case (prg_mode_e'(control[3:2]))
              PRG_SWITCH_32K, PRG_SWITCH_32K_ALT: window = '0;
              PRG_FIX_FIRST: window = acc.addr[14] ? bank : 4'd0;
              default: window = acc.addr[14] ? 4'(bank_count - 5'd1) : bank;
            endcase
            if (control[3:2] == PRG_SWITCH_32K || control[3:2] == PRG_SWITCH_32K_ALT) begin
              off = bank[3:1] * 32'h8000 + acc.addr[14:0];
            end else begin
              off = window * 32'h4000 + acc.addr[13:0];
            end
          end
        end
      end
      SPACE_PRG_RAM: begin
        r.target = TGT_PRG_RAM;
        if (acc.addr >= 16'h6000 && acc.addr < 16'h8000 && !prg_bank[RamDisableBit]) begin
          r.access_ok = 1'b1;
          off = ram_base + acc.addr[12:0];
        end
      end
      default: r.target = TGT_CHR_ROM;
    endcase
    r.offset = off[OffsetW-1:0];
    r.mirror = control[1:0];
    return r;
  endfunction

  // register writes, result compare, then prediction of the newly accepted access
  always @(posedge clk_i or negedge rst_ni) begin
    translation_t got;
    translation_t want;
    access_t      acc;
    if (!rst_ni) begin
      shift_word = '0;
      shift_cnt = '0;
      control = ControlReset;
      chr_low = '0;
      chr_high = '0;
      prg_bank = '0;
      bank_count = BankCountReset;
      ram_base = '0;
      translations_q.delete();
      fail_count_o = 0;
      checked_o = 0;
      loads_o = 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PaddrW-1:2])
          CFG_PRG_BANK_COUNT: bank_count = pwdata_i[BankW-1:0];
          CFG_PRG_RAM_BASE:   ram_base = pwdata_i[RamBaseW-1:0];
          default: ;
        endcase
      end

      if (res_tvalid_i && res_tready_i) begin
        got.access_ok = res_tuser_i[0];
        got.target = res_tuser_i[2:1];
        got.offset = res_tdata_i[OffsetW-1:0];
        got.mirror = res_tdata_i[19:18];
        got.loaded = res_tuser_i[3];
        if (translations_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MaxReports)
            $display("result transfer with no access outstanding: tdata %06h tuser %01h",
                     res_tdata_i, res_tuser_i);
        end else begin
          want = translations_q.pop_front();
          checked_o++;
          if (got !== want || res_tdata_i[23:20] !== 4'd0) begin
            fail_count_o++;
            if (fail_count_o <= MaxReports) begin
              $display("mismatch on result %0d: expected ok %0b mem %0d offset %05h %s",
                       checked_o, want.access_ok, want.target, want.offset, "");
              $display("  expected mirror %0d loaded %0b", want.mirror, want.loaded);
              $display("  got ok %0b mem %0d offset %05h mirror %0d loaded %0b pad %0h",
                       got.access_ok, got.target, got.offset, got.mirror, got.loaded,
                       res_tdata_i[23:20]);
            end
          end
        end
      end

      if (acc_tvalid_i && acc_tready_i) begin
        acc.addr = acc_tdata_i[15:0];
        acc.data = acc_tdata_i[23:16];
        acc.mode = acc_tuser_i[1:0];
        acc.is_write = acc_tuser_i[2];
        want = translate_access(acc);
        if (want.loaded) loads_o++;
        translations_q.push_back(want);
      end
      pending_o <= translations_q.size();
    end
  end

endmodule

[sim/tb_serial_bank_mapper.sv]
// tb_serial_bank_mapper: stimulus and verdict for the serial bank mapper
// drives bus accesses and register writes; checking lives in serial_bank_mapper_checker
// depends on sbm_pkg, serial_bank_mapper, serial_bank_mapper_checker
`timescale 1ns / 1ps

module tb_serial_bank_mapper;
  import sbm_pkg::*;

  localparam int ResetCycles = 11;
  localparam int SettleCycles = 6;
  localparam int LongHoldCycles = 120;
  localparam int RunLimitNs = 200000;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata = '0;   // bus_address[15:0], write_data[23:16]
  logic [2:0]        s_axis_tuser = '0;   // mode[1:0], is_write[2]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;        // phys_offset[17:0], mirror_mode[19:18], zero[23:20]
  logic [3:0]        m_axis_tuser;        // access_ok[0], target_memory[2:1], register_loaded[3]
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int results_pending;
  int results_checked;
  int register_loads;

  // sender pacing state
  logic offering = 1'b0;
  logic steady = 1'b0;
  logic long_hold_req = 1'b0;
  int   burst_left = 0;
  int   items_sent = 0;

  serial_bank_mapper u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  serial_bank_mapper_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_tvalid_i (s_axis_tvalid),
    .acc_tready_i (s_axis_tready),
    .acc_tdata_i  (s_axis_tdata),
    .acc_tuser_i  (s_axis_tuser),
    .res_tvalid_i (m_axis_tvalid),
    .res_tready_i (m_axis_tready),
    .res_tdata_i  (m_axis_tdata),
    .res_tuser_i  (m_axis_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (results_pending),
    .checked_o    (results_checked),
    .loads_o      (register_loads)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RunLimitNs);
    $display("Test completed with failures");
    $finish;
  end

  // result side: stall styles in random spans, plus one long hold on request
  initial begin : result_sink
    int style;
    int span;
    int k;
    wait (rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (k = 0; k < LongHoldCycles; k++) @(posedge clk_i);
      end
      style = $urandom_range(0, 3);
      span = $urandom_range(8, 48);
      for (k = 0; k < span && !long_hold_req; k++) begin
        case (style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((k % 3) != 2);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // one access transfer, then a gap if it ends a burst
  task automatic send(input space_e mode, input logic wr, input logic [AddrW-1:0] addr,
                      input logic [DataW-1:0] data);
    s_axis_tvalid <= 1'b1;
    offering = 1'b1;
    s_axis_tdata <= {data, addr};
    s_axis_tuser <= {wr, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (steady || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    end
  endtask

  // five serial bits into one register, lsb first
  task automatic serial_load(input reg_sel_e sel, input logic [4:0] value);
    int b;
    for (b = 0; b < 5; b++)
      send(SPACE_PRG_ROM, 1'b1,
           {1'b1, (b == 4) ? 2'(sel) : 2'($urandom_range(0, 3)), 13'($urandom)},
           {1'b0, 6'($urandom), value[b]});
  endtask

  // stop offering and wait until every result has arrived
  task automatic drain();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write: setup cycle, then access cycle
  task automatic write_cfg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [BankW-1:0] count, input logic [RamBaseW-1:0] base);
    drain();
    write_cfg(CFG_PRG_BANK_COUNT, 32'(count));
    write_cfg(CFG_PRG_RAM_BASE, 32'(base));
  endtask

  // mostly well-formed serial loads and in-window accesses, some noise
  task automatic random_traffic(input int count);
    int          n;
    int          k;
    int          pick;
    space_e      mode;
    logic        wr;
    logic [15:0] addr;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        serial_load(reg_sel_e'($urandom_range(0, 3)), 5'($urandom));
        n += 5;
      end else if (pick < 30) begin
        // partial serial word, usually abandoned by a clear
        k = $urandom_range(1, 4);
        repeat (k) send(SPACE_PRG_ROM, 1'b1, 16'h8000 | 16'($urandom), 8'($urandom) & 8'h7F);
        if ($urandom_range(0, 3) != 0)
          send(SPACE_PRG_ROM, 1'b1, 16'h8000 | 16'($urandom), 8'h80 | 8'($urandom));
        n += k + 1;
      end else begin
        pick = $urandom_range(0, 9);
        mode = (pick < 3) ? SPACE_CHR : (pick < 6) ? SPACE_PRG_ROM :
               (pick < 9) ? SPACE_PRG_RAM : SPACE_NONE;
        wr = (mode == SPACE_PRG_ROM) ? ($urandom_range(0, 3) == 0) : 1'($urandom);
        addr = 16'($urandom);
        if ($urandom_range(0, 4) != 0) begin
          case (mode)
            SPACE_CHR:     addr = addr & 16'h1FFF;
            SPACE_PRG_ROM: addr = addr | 16'h8000;
            SPACE_PRG_RAM: addr = 16'h6000 | (addr & 16'h1FFF);
            default: ;
          endcase
        end
        send(mode, wr, addr, 8'($urandom));
        n++;
      end
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int p;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: window edges, every space, register port corners
    apply_setting(5'd8, 15'h7FFF);
    send(SPACE_CHR, 1'b0, 16'h0000, 8'h00);
    send(SPACE_CHR, 1'b1, 16'h1FFF, 8'hFF);
    send(SPACE_CHR, 1'b0, 16'h2000, 8'h00);
    send(SPACE_PRG_ROM, 1'b0, 16'h8000, 8'h00);
    send(SPACE_PRG_ROM, 1'b0, 16'hFFFF, 8'hFF);
    send(SPACE_PRG_ROM, 1'b0, 16'h7FFF, 8'h00);
    send(SPACE_PRG_RAM, 1'b1, 16'h6000, 8'hFF);
    send(SPACE_PRG_RAM, 1'b0, 16'h7FFF, 8'h00);
    send(SPACE_PRG_RAM, 1'b1, 16'h5FFF, 8'h00);
    send(SPACE_NONE, 1'b1, 16'hFFFF, 8'hFF);
    // register port write below the window is ignored
    send(SPACE_PRG_ROM, 1'b1, 16'h7FFF, 8'h01);
    // one bit in, then a clear
    send(SPACE_PRG_ROM, 1'b1, 16'h8000, 8'h01);
    send(SPACE_PRG_ROM, 1'b1, 16'hC000, 8'h80);
    // 4K character banks, fixed last bank, horizontal mirroring
    serial_load(SEL_CONTROL, 5'h1F);
    send(SPACE_CHR, 1'b0, 16'h1000, 8'h00);
    send(SPACE_PRG_ROM, 1'b0, 16'hC123, 8'h00);
    // bank 15 with program RAM disabled
    serial_load(SEL_PRG_BANK, 5'h1F);
    send(SPACE_PRG_RAM, 1'b0, 16'h6000, 8'h00);

    // random phases, one register setting each
    for (p = 0; p < 6; p++) begin
      case (p)
        0: apply_setting(5'd1, 15'h0000);
        1: apply_setting(5'd16, 15'h1000);
        2: apply_setting(5'd0, 15'($urandom));
        3: apply_setting(5'd31, 15'($urandom));
        4: apply_setting(5'd17, 15'($urandom));
        default: apply_setting(5'($urandom), 15'($urandom));
      endcase
      if (p == 0) begin
        // long result stall while accesses keep coming
        steady = 1'b1;
        long_hold_req = 1'b1;
        random_traffic(40);
        steady = 1'b0;
        random_traffic(35);
      end else begin
        random_traffic(75);
      end
    end

    drain();
    @(negedge clk_i);
    $display("ran %0d accesses over 7 register settings", items_sent);
    $display("checked %0d results, %0d serial register loads", results_checked, register_loads);
    if (fail_count == 0 && results_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
